// ===== src/kls_pkg.sv =====
package kls_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned DATA_BITS_DEF = 32;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 7;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_SORT   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_SHIFT,
    S_SORT_HOLD,
    S_SORT_CMP,
    S_SORT_PUT
  } state_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [KEY_W-1:0]  rec_key;
    logic [WORD_W-1:0] rec_data;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  out_key;
    logic [WORD_W-1:0] out_data;
    logic [POS_W-1:0]  fill;
  } result_t;

endpackage

// ===== src/kls_ram.sv =====
module kls_ram
  import kls_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned WIDTH = KEY_W + DATA_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/keyed_record_list_with_sort.sv =====
// channel  | ports                  | handshake
// ---------+------------------------+----------------------------------------
// command  | item_i, start, busy    | word taken at edge with start && !busy
// result   | result_o, valid_o      | one-cycle strobe, receiver cannot stall
//
// clear and refused commands answer from idle; insert scans the list for a duplicate
// key, one read a cycle; remove shifts the later entries down, one shift a cycle;
// sort: insertion sort, bounded by the single read port of the record memory.
// rst_ni clears the fill count and the sequencer, memory content is not cleared.
// busy is high from acceptance until the result strobe for commands leaving idle.
module keyed_record_list_with_sort
  import kls_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    valid_o,
  output result_t result_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = KEY_W + DATA_BITS;

  state_e   state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;      // next read index / outer sort index
  logic [CW-1:0] jdx_q, jdx_d;      // sort hole position
  logic [AW-1:0] wa_q, wa_d;        // pending shift write address
  logic          pend_q, pend_d;    // read data in flight
  logic          rm_q, rm_d;        // fetch belongs to a remove
  logic [KEY_W-1:0]     key_q, key_d;
  logic [DATA_BITS-1:0] data_q, data_d;
  logic    valid_q, valid_d;
  result_t res_q, res_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [KEY_W-1:0]     rd_key;
  logic [DATA_BITS-1:0] rd_data;
  logic [31:0]   pos_w;
  logic          accept;
  logic [CW-1:0] idx_inc;

  kls_ram #(.DEPTH(CAPACITY), .WIDTH(RW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key  = rdata[RW-1 -: KEY_W];
  assign rd_data = rdata[DATA_BITS-1:0];
  assign pos_w   = 32'(item_i.position);
  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign idx_inc = idx_q + CW'(1);
  assign valid_o  = valid_q;
  assign result_o = res_q;

  // reads and writes never hit the same entry in one cycle, so no forwarding
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    jdx_d   = jdx_q;
    wa_d    = wa_q;
    pend_d  = 1'b0;
    rm_d    = rm_q;
    key_d   = key_q;
    data_d  = data_q;
    valid_d = 1'b0;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = {key_q, data_q};
    raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.out_key  = '0;
          res_d.out_data = '0;
          res_d.status   = ST_OK;
          case (item_i.command)
            CMD_CLEAR: begin
              count_d = '0;
              valid_d = 1'b1;
            end
            CMD_INSERT: begin
              if (32'(count_q) == 32'(CAPACITY)) begin
                res_d.status = ST_FULL;
                valid_d      = 1'b1;
              end else begin
                key_d   = item_i.rec_key;
                data_d  = DATA_BITS'(item_i.rec_data);
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            CMD_REMOVE, CMD_READ: begin
              if (pos_w == 32'd0 || pos_w > 32'(count_q)) begin
                res_d.status = ST_BAD;
                valid_d      = 1'b1;
              end else begin
                raddr   = AW'(pos_w - 32'd1);
                idx_d   = CW'(pos_w);
                rm_d    = (item_i.command == CMD_REMOVE);
                state_d = S_FETCH;
              end
            end
            CMD_SORT: begin
              if (count_q == '0) begin
                res_d.status = ST_BAD;
                valid_d      = 1'b1;
              end else if (count_q == CW'(1)) begin
                valid_d = 1'b1;
              end else begin
                raddr   = AW'(1);
                idx_d   = CW'(1);
                state_d = S_SORT_HOLD;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_FETCH: begin
        key_d          = rd_key;
        data_d         = rd_data;
        res_d.out_key  = rd_key;
        res_d.out_data = WORD_W'(rd_data);
        if (rm_q) begin
          state_d = S_SHIFT;
        end else begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = rdata;
        end
        if (idx_q < count_q) begin
          raddr  = idx_q[AW-1:0];
          wa_d   = AW'(idx_q - CW'(1));
          idx_d  = idx_inc;
          pend_d = 1'b1;
        end else begin
          count_d = count_q - CW'(1);
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (pend_q && rd_key == key_q) begin
          res_d.status = ST_DUP;
          valid_d      = 1'b1;
          state_d      = S_IDLE;
        end else if (idx_q < count_q) begin
          raddr  = idx_q[AW-1:0];
          idx_d  = idx_inc;
          pend_d = 1'b1;
        end else begin
          we      = 1'b1;
          waddr   = count_q[AW-1:0];
          count_d = count_q + CW'(1);
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SORT_HOLD: begin
        key_d   = rd_key;
        data_d  = rd_data;
        jdx_d   = idx_q;
        raddr   = AW'(idx_q - CW'(1));
        state_d = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if ($signed(key_q) < $signed(rd_key)) begin
          // move the larger entry up one place
          we    = 1'b1;
          waddr = jdx_q[AW-1:0];
          wdata = rdata;
          jdx_d = jdx_q - CW'(1);
          if (jdx_q > CW'(1)) begin
            raddr = AW'(jdx_q - CW'(2));
          end else begin
            state_d = S_SORT_PUT;
          end
        end else begin
          we    = 1'b1;
          waddr = jdx_q[AW-1:0];
          idx_d = idx_inc;
          if (idx_inc < count_q) begin
            raddr   = idx_inc[AW-1:0];
            state_d = S_SORT_HOLD;
          end else begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SORT_PUT: begin
        we    = 1'b1;
        waddr = jdx_q[AW-1:0];
        idx_d = idx_inc;
        if (idx_inc < count_q) begin
          raddr   = idx_inc[AW-1:0];
          state_d = S_SORT_HOLD;
        end else begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.fill = POS_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    jdx_q  <= jdx_d;
    wa_q   <= wa_d;
    rm_q   <= rm_d;
    key_q  <= key_d;
    data_q <= data_d;
    res_q  <= res_d;
  end

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(CAPACITY)) else $error("fill count above capacity");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.command == CMD_INSERT && 32'(count_q) == 32'(CAPACITY))
    |=> (valid_o && result_o.status == ST_FULL)) else $error("full insert not refused");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.command == CMD_CLEAR) |=> (valid_o && count_q == '0))
    else $error("clear did not empty the list");

endmodule

// ===== verif/keyed_record_list_with_sort_test.sv =====
module keyed_record_list_with_sort_test
  import kls_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = CAPACITY_DEF;
  // tail drain: a wide margin over the length of a full sort
  localparam int unsigned TAIL_CYCLES = 4 * CAP * CAP;

  // one queued command word plus its pacing
  typedef struct {
    item_t word;
    int    gap;    // idle cycles before offering this word
    bit    drain;  // hold the word until no result is outstanding
  } cmd_slot_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    valid_o;
  result_t result_o;

  keyed_record_list_with_sort dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  // clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  cmd_slot_t   cmd_q[$];      // words waiting to be driven
  result_t     answer_q[$];   // predicted results, oldest first
  int unsigned mismatches = 0;
  bit          gen_done   = 1'b0;

  // shadow copy of the record list
  logic [KEY_W-1:0]  shadow_key  [CAP];
  logic [WORD_W-1:0] shadow_data [CAP];
  int unsigned       shadow_fill = 0;

  // fill count as guessed by the stimulus generator, steers positions
  int unsigned gen_fill = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // compute the result of one accepted word and update the shadow list
  function automatic result_t list_apply(input item_t w);
    result_t           r;
    logic [KEY_W-1:0]  hk;
    logic [WORD_W-1:0] hd;
    int                j;
    bit                dup;
    r        = '0;
    r.status = ST_OK;
    case (w.command)
      CMD_CLEAR: shadow_fill = 0;
      CMD_INSERT: begin
        if (shadow_fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          dup = 1'b0;
          for (int i = 0; i < shadow_fill; i++)
            if (shadow_key[i] == w.rec_key) dup = 1'b1;
          if (dup) begin
            r.status = ST_DUP;
          end else begin
            shadow_key[shadow_fill]  = w.rec_key;
            shadow_data[shadow_fill] = w.rec_data;
            shadow_fill++;
          end
        end
      end
      CMD_REMOVE, CMD_READ: begin
        if (w.position == 0 || w.position > shadow_fill) begin
          r.status = ST_BAD;
        end else begin
          r.out_key  = shadow_key[w.position-1];
          r.out_data = shadow_data[w.position-1];
          if (w.command == CMD_REMOVE) begin
            // close the gap
            for (int i = w.position; i < shadow_fill; i++) begin
              shadow_key[i-1]  = shadow_key[i];
              shadow_data[i-1] = shadow_data[i];
            end
            shadow_fill--;
          end
        end
      end
      CMD_SORT: begin
        if (shadow_fill == 0) begin
          r.status = ST_BAD;
        end else begin
          // insertion sort, signed ascending keys
          for (int i = 1; i < shadow_fill; i++) begin
            hk = shadow_key[i];
            hd = shadow_data[i];
            j  = i;
            while (j > 0 && $signed(hk) < $signed(shadow_key[j-1])) begin
              shadow_key[j]  = shadow_key[j-1];
              shadow_data[j] = shadow_data[j-1];
              j--;
            end
            shadow_key[j]  = hk;
            shadow_data[j] = hd;
          end
        end
      end
      default: ;
    endcase
    r.fill = shadow_fill[POS_W-1:0];
    return r;
  endfunction

  // driver: offers queued words, predicts on acceptance
  int wait_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      item_i   <= '0;
      wait_cnt <= 0;
    end else begin
      if (start && !busy) answer_q.push_back(list_apply(item_i));
      // a new word may go out when nothing is being offered or the last one was taken
      if (!start || !busy) begin
        if (cmd_q.size() == 0) begin
          start <= 1'b0;
        end else if (wait_cnt < cmd_q[0].gap) begin
          wait_cnt <= wait_cnt + 1;
          start    <= 1'b0;
        end else if (cmd_q[0].drain && (answer_q.size() != 0 || (start && !busy))) begin
          start <= 1'b0;
        end else begin
          item_i   <= cmd_q[0].word;
          start    <= 1'b1;
          wait_cnt <= 0;
          void'(cmd_q.pop_front());
        end
      end
    end
  end

  // monitor: every strobe is matched against the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && valid_o) begin
      if (answer_q.size() == 0) begin
        report("unexpected word", 64'(result_o.out_data), 64'd0);
      end else begin
        want = answer_q.pop_front();
        if (result_o.status !== want.status)
          report("status", 64'(result_o.status), 64'(want.status));
        if (result_o.out_key !== want.out_key)
          report("out_key", 64'(result_o.out_key), 64'(want.out_key));
        if (result_o.out_data !== want.out_data)
          report("out_data", 64'(result_o.out_data), 64'(want.out_data));
        if (result_o.fill !== want.fill)
          report("fill", 64'(result_o.fill), 64'(want.fill));
      end
    end
  end

  task automatic push_cmd(input logic [2:0] c, input logic [31:0] k, input logic [31:0] d,
                          input int unsigned p, input int gap, input bit drain);
    cmd_slot_t s;
    s.word.command  = c;
    s.word.rec_key  = k;
    s.word.rec_data = d;
    s.word.position = p[POS_W-1:0];
    s.gap           = gap;
    s.drain         = drain;
    cmd_q.push_back(s);
    // rough tracking, only used to aim positions
    case (c)
      CMD_CLEAR:  gen_fill = 0;
      CMD_INSERT: if (gen_fill < CAP) gen_fill++;
      CMD_REMOVE: if (p >= 1 && p <= gen_fill) gen_fill--;
      default: ;
    endcase
  endtask

  // keys: a small pool makes duplicates likely, plus the extremes
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0, 1:    return 32'($signed($urandom_range(0, 31)) - 16);
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_pos();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, gen_fill > 0 ? gen_fill : 1);
    return $urandom_range(0, 64);
  endfunction

  // stimulus
  initial begin
    int          mode;
    int          gap;
    bit          quiet;
    int unsigned roll;
    logic [2:0]  c;

    // directed: empty list corners, extreme keys, duplicates, bad positions
    push_cmd(CMD_CLEAR,  0, 0, 0, 0, 0);
    push_cmd(CMD_SORT,   0, 0, 0, 0, 0);
    push_cmd(CMD_READ,   0, 0, 1, 0, 0);
    push_cmd(CMD_REMOVE, 0, 0, 0, 0, 0);
    push_cmd(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 0);
    push_cmd(CMD_INSERT, 32'h8000_0000, 32'h0000_0000, 0, 0, 0);
    push_cmd(CMD_INSERT, 32'h0000_0000, 32'ha5a5_5a5a, 0, 0, 0);
    push_cmd(CMD_INSERT, 32'hffff_ffff, 32'h5a5a_a5a5, 0, 0, 0);
    push_cmd(CMD_INSERT, 32'h8000_0000, 32'h1234_5678, 0, 0, 0);
    push_cmd(CMD_READ,   0, 0, 0, 0, 0);
    push_cmd(CMD_READ,   0, 0, 5, 0, 0);
    push_cmd(CMD_READ,   0, 0, 64, 0, 0);
    push_cmd(CMD_READ,   0, 0, 4, 0, 0);
    push_cmd(CMD_SORT,   0, 0, 0, 0, 0);
    push_cmd(CMD_READ,   0, 0, 1, 0, 0);
    push_cmd(CMD_READ,   0, 0, 4, 0, 0);
    push_cmd(CMD_REMOVE, 0, 0, 4, 0, 0);
    push_cmd(CMD_REMOVE, 0, 0, 1, 0, 0);
    push_cmd(CMD_REMOVE, 0, 0, 2, 0, 0);
    push_cmd(CMD_REMOVE, 0, 0, 1, 0, 0);
    push_cmd(CMD_SORT,   0, 0, 0, 0, 0);

    // random: phases that fill, mix and drain the list
    mode  = 0;
    quiet = 1'b0;
    for (int n = 0; n < 1800; n++) begin
      if (n % 100 == 0) begin
        mode  = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (mode)
        0:       c = roll < 80 ? CMD_INSERT : roll < 88 ? CMD_READ : roll < 95 ? CMD_REMOVE : CMD_SORT;
        1:       c = roll < 40 ? CMD_INSERT : roll < 65 ? CMD_READ : roll < 88 ? CMD_REMOVE
                   : roll < 98 ? CMD_SORT : CMD_CLEAR;
        default: c = roll < 25 ? CMD_INSERT : roll < 45 ? CMD_READ : roll < 92 ? CMD_REMOVE
                   : roll < 98 ? CMD_SORT : CMD_CLEAR;
      endcase
      // idle bursts, none in the closing stretch or quiet phases
      gap = (n < 1500 && !quiet && $urandom_range(0, 99) < 30) ? $urandom_range(1, 7) : 0;
      // one word waits until all results are back
      push_cmd(c, pick_key(), $urandom, pick_pos(), gap, n == 900);
    end
    gen_done = 1'b1;
  end

  // reset, wait for completion, verdict
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (gen_done);
    while (cmd_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
